// File: sv/lir_pkg.sv
// Shared types and constants for the linear interpolating IQ upsampler.
`default_nettype none
package lir_pkg;

    localparam int SampleBits  = 16;
    localparam int SampleW     = 16;
    localparam int InRateW     = 21;
    localparam int OutRateW    = 25;
    localparam int CountW      = 64;
    localparam int FracW       = 17;
    localparam int FracSteps   = 16;
    localparam int ByteW       = 8;
    localparam int ByteMax     = 127;
    localparam int MaxRatio    = 64;
    localparam int QueueDepth  = 2;
    localparam int StepW       = 7;
    localparam int MulSteps    = OutRateW;
    localparam int DivSteps    = CountW;
    localparam int InDataW     = 2 * SampleW;
    localparam int OutDataW    = 2 * ByteW;
    localparam int CfgIdxW     = 1;
    localparam int CfgDataW    = OutRateW;
    localparam int ProdW       = SampleW + 1 + FracW + 1;
    localparam int YW          = ProdW + 1;
    localparam int PW          = YW + 7;
    localparam int RoundShift  = SampleBits + 15;
    localparam int RW          = PW - RoundShift;

    localparam logic [InRateW-1:0]  InRateReset  = 21'd48000;
    localparam logic [OutRateW-1:0] OutRateReset = 25'd2000000;
    localparam logic [FracW-1:0]    FracOne      = 17'h10000;

    localparam logic [CfgIdxW-1:0] CfgIdxInRate  = 1'b0;
    localparam logic [CfgIdxW-1:0] CfgIdxOutRate = 1'b1;

    typedef enum logic {
        ARITH_MUL,
        ARITH_DIV
    } arith_op_t;

    typedef struct packed {
        logic                  start;
        arith_op_t             op;
        logic [CountW-1:0]     a;
        logic [OutRateW-1:0]   b;
        logic [OutRateW-1:0]   rem;
        logic [StepW-1:0]      steps;
    } arith_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [CountW-1:0] result;
    } arith_rsp_t;

    typedef struct packed {
        logic                      first;
        logic signed [SampleW-1:0] in_q;
        logic signed [SampleW-1:0] in_i;
    } item_t;

    typedef struct packed {
        logic signed [SampleW-1:0] prev_i;
        logic signed [SampleW-1:0] prev_q;
        logic signed [SampleW-1:0] cur_i;
        logic signed [SampleW-1:0] cur_q;
        logic [FracW-1:0]          frac;
        logic                      last;
        logic                      ovr;
    } scale_req_t;

endpackage
`default_nettype wire

// File: sv/lir_fifo.sv
// Small first-word-fall-through queue between the front and back parts.
`default_nettype none
module lir_fifo #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 2
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] din,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      dout,
    output logic                  avail
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign avail   = (count_reg != '0);
    assign dout    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && avail;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule
`default_nettype wire

// File: sv/lir_front.sv
// Input side: accepts sample requests and marks the first one after reset.
`default_nettype none
module lir_front (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [lir_pkg::InDataW-1:0]  s_axis_tdata,
    input  wire logic                         q_full,
    output logic                              q_push,
    output lir_pkg::item_t                    q_item
);
    import lir_pkg::*;

    logic primed_reg, primed_next;

    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full;

    always_comb begin
        q_item.in_i  = s_axis_tdata[SampleW-1:0];
        q_item.in_q  = s_axis_tdata[InDataW-1:SampleW];
        q_item.first = !primed_reg;
        primed_next  = primed_reg || q_push;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            primed_reg <= 1'b0;
        end else begin
            primed_reg <= primed_next;
        end
    end

endmodule
`default_nettype wire

// File: sv/lir_arith.sv
// Shared iterative unit: shift-add multiply and restoring divide, one bit per cycle.
`default_nettype none
module lir_arith (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire lir_pkg::arith_req_t req,
    output lir_pkg::arith_rsp_t      rsp
);
    import lir_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    arith_op_t           op_reg, op_next;
    logic [StepW-1:0]    cnt_reg, cnt_next;
    logic [CountW-1:0]   a_reg, a_next;
    logic [OutRateW-1:0] b_reg, b_next;
    logic [CountW-1:0]   acc_reg, acc_next;
    logic [OutRateW:0]   rem_sh;
    logic [OutRateW:0]   rem_sub;
    logic                take;

    assign rem_sh  = {acc_reg[OutRateW-1:0], a_reg[CountW-1]};
    assign take    = (rem_sh >= {1'b0, b_reg});
    assign rem_sub = rem_sh - {1'b0, b_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        if (busy_reg) begin
            unique case (op_reg)
                ARITH_MUL: begin
                    acc_next = acc_reg + (b_reg[0] ? a_reg : '0);
                    a_next   = {a_reg[CountW-2:0], 1'b0};
                    b_next   = {1'b0, b_reg[OutRateW-1:1]};
                end
                ARITH_DIV: begin
                    // partial remainder stays below the divisor, so 25 bits hold it
                    a_next   = {a_reg[CountW-2:0], take};
                    acc_next = take
                        ? {{(CountW-OutRateW){1'b0}}, rem_sub[OutRateW-1:0]}
                        : {{(CountW-OutRateW){1'b0}}, rem_sh[OutRateW-1:0]};
                end
            endcase
            cnt_next = cnt_reg - StepW'(1);
            if (cnt_reg == StepW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (req.start) begin
            busy_next = 1'b1;
            op_next   = req.op;
            cnt_next  = req.steps;
            a_next    = req.a;
            b_next    = req.b;
            acc_next  = (req.op == ARITH_MUL)
                ? '0 : {{(CountW-OutRateW){1'b0}}, req.rem};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= ARITH_MUL;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    always_comb begin
        rsp.busy   = busy_reg;
        rsp.done   = done_reg;
        rsp.result = (op_reg == ARITH_MUL) ? acc_reg : a_reg;
    end

endmodule
`default_nettype wire

// File: sv/lir_back.sv
// Back part: walks the due output indexes of one sample and issues interpolation requests.
`default_nettype none
module lir_back #(
    parameter int MAX_RATIO = lir_pkg::MaxRatio
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire lir_pkg::item_t                item,
    input  wire logic                          item_valid,
    output logic                               item_pop,
    input  wire logic [lir_pkg::InRateW-1:0]   in_rate,
    input  wire logic [lir_pkg::OutRateW-1:0]  out_rate,
    output lir_pkg::arith_req_t                arith_req,
    input  wire lir_pkg::arith_rsp_t           arith_rsp,
    output lir_pkg::scale_req_t                sreq,
    output logic                               sreq_valid,
    input  wire logic                          sreq_ready
);
    import lir_pkg::*;

    localparam int CNT_W = $clog2(MAX_RATIO + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIRST,
        ST_MUL_LIM,
        ST_MUL_POS,
        ST_CHECK,
        ST_DIV_FRAC,
        ST_ISSUE,
        ST_OVR_DIV
    } state_t;

    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [CountW-1:0]         in_cnt_reg, in_cnt_next;
    logic [CountW-1:0]         out_cnt_reg, out_cnt_next;
    logic [CountW-1:0]         limit_reg, limit_next;
    logic [CountW-1:0]         base_reg, base_next;
    logic [CountW-1:0]         pos_reg, pos_next;
    logic [CountW-1:0]         pos_nx_reg, pos_nx_next;
    logic [FracW-1:0]          frac_reg, frac_next;
    logic signed [SampleW-1:0] cur_i_reg, cur_i_next;
    logic signed [SampleW-1:0] cur_q_reg, cur_q_next;
    logic signed [SampleW-1:0] prev_i_reg, prev_i_next;
    logic signed [SampleW-1:0] prev_q_reg, prev_q_next;

    logic [InRateW-1:0]  ir;
    logic [OutRateW-1:0] orr;
    logic [OutRateW-1:0] ir_b;
    logic [CountW-1:0]   ir64;
    logic [CountW-1:0]   or64;
    logic [CountW-1:0]   pos_d;
    logic                at_max;
    logic                nx_due;
    logic                iss_last;
    logic                iss_ovr;

    // a zero rate counts as one
    assign ir     = (in_rate == '0) ? InRateW'(1) : in_rate;
    assign orr    = (out_rate == '0) ? OutRateW'(1) : out_rate;
    assign ir_b   = {{(OutRateW-InRateW){1'b0}}, ir};
    assign ir64   = {{(CountW-InRateW){1'b0}}, ir};
    assign or64   = {{(CountW-OutRateW){1'b0}}, orr};
    assign pos_d  = pos_reg - base_reg;
    assign at_max = (cnt_reg == CNT_W'(MAX_RATIO - 1));
    assign nx_due = (pos_nx_reg <= limit_reg);
    assign iss_last = at_max || !nx_due;
    assign iss_ovr  = at_max && nx_due;

    assign sreq_valid = (state_reg == ST_FIRST) || (state_reg == ST_ISSUE);

    always_comb begin
        sreq.cur_i  = cur_i_reg;
        sreq.cur_q  = cur_q_reg;
        if (state_reg == ST_FIRST) begin
            sreq.prev_i = cur_i_reg;
            sreq.prev_q = cur_q_reg;
            sreq.frac   = '0;
            sreq.last   = 1'b1;
            sreq.ovr    = 1'b0;
        end else begin
            sreq.prev_i = prev_i_reg;
            sreq.prev_q = prev_q_reg;
            sreq.frac   = frac_reg;
            sreq.last   = iss_last;
            sreq.ovr    = iss_ovr;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        in_cnt_next  = in_cnt_reg;
        out_cnt_next = out_cnt_reg;
        limit_next   = limit_reg;
        base_next    = base_reg;
        pos_next     = pos_reg;
        pos_nx_next  = pos_nx_reg;
        frac_next    = frac_reg;
        cur_i_next   = cur_i_reg;
        cur_q_next   = cur_q_reg;
        prev_i_next  = prev_i_reg;
        prev_q_next  = prev_q_reg;
        item_pop     = 1'b0;
        arith_req    = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (item_valid) begin
                    item_pop   = 1'b1;
                    cur_i_next = item.in_i;
                    cur_q_next = item.in_q;
                    if (item.first) begin
                        state_next = ST_FIRST;
                    end else begin
                        in_cnt_next     = in_cnt_reg + CountW'(1);
                        arith_req.start = 1'b1;
                        arith_req.op    = ARITH_MUL;
                        arith_req.a     = in_cnt_reg + CountW'(1);
                        arith_req.b     = orr;
                        arith_req.steps = StepW'(MulSteps);
                        state_next      = ST_MUL_LIM;
                    end
                end
            end
            ST_FIRST: begin
                if (sreq_ready) begin
                    prev_i_next  = cur_i_reg;
                    prev_q_next  = cur_q_reg;
                    out_cnt_next = CountW'(1);
                    state_next   = ST_IDLE;
                end
            end
            ST_MUL_LIM: begin
                if (arith_rsp.done) begin
                    limit_next      = arith_rsp.result;
                    base_next       = arith_rsp.result - or64;
                    arith_req.start = 1'b1;
                    arith_req.op    = ARITH_MUL;
                    arith_req.a     = out_cnt_reg;
                    arith_req.b     = ir_b;
                    arith_req.steps = StepW'(MulSteps);
                    state_next      = ST_MUL_POS;
                end
            end
            ST_MUL_POS: begin
                if (arith_rsp.done) begin
                    pos_next   = arith_rsp.result;
                    cnt_next   = '0;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (pos_reg <= limit_reg) begin
                    pos_nx_next = pos_reg + ir64;
                    if (pos_reg < base_reg) begin
                        frac_next  = '0;
                        state_next = ST_ISSUE;
                    end else if (pos_d >= or64) begin
                        frac_next  = FracOne;
                        state_next = ST_ISSUE;
                    end else begin
                        arith_req.start = 1'b1;
                        arith_req.op    = ARITH_DIV;
                        arith_req.a     = '0;
                        arith_req.b     = orr;
                        arith_req.rem   = pos_d[OutRateW-1:0];
                        arith_req.steps = StepW'(FracSteps);
                        state_next      = ST_DIV_FRAC;
                    end
                end else begin
                    prev_i_next = cur_i_reg;
                    prev_q_next = cur_q_reg;
                    state_next  = ST_IDLE;
                end
            end
            ST_DIV_FRAC: begin
                if (arith_rsp.done) begin
                    frac_next  = {1'b0, arith_rsp.result[FracSteps-1:0]};
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (sreq_ready) begin
                    out_cnt_next = out_cnt_reg + CountW'(1);
                    cnt_next     = cnt_reg + CNT_W'(1);
                    pos_next     = pos_nx_reg;
                    if (iss_last) begin
                        if (iss_ovr) begin
                            // skip the remaining due outputs
                            arith_req.start = 1'b1;
                            arith_req.op    = ARITH_DIV;
                            arith_req.a     = limit_reg;
                            arith_req.b     = ir_b;
                            arith_req.rem   = '0;
                            arith_req.steps = StepW'(DivSteps);
                            state_next      = ST_OVR_DIV;
                        end else begin
                            prev_i_next = cur_i_reg;
                            prev_q_next = cur_q_reg;
                            state_next  = ST_IDLE;
                        end
                    end else begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_OVR_DIV: begin
                if (arith_rsp.done) begin
                    out_cnt_next = arith_rsp.result + CountW'(1);
                    prev_i_next  = cur_i_reg;
                    prev_q_next  = cur_q_reg;
                    state_next   = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            in_cnt_reg  <= '0;
            out_cnt_reg <= '0;
            prev_i_reg  <= '0;
            prev_q_reg  <= '0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            in_cnt_reg  <= in_cnt_next;
            out_cnt_reg <= out_cnt_next;
            prev_i_reg  <= prev_i_next;
            prev_q_reg  <= prev_q_next;
        end
        limit_reg  <= limit_next;
        base_reg   <= base_next;
        pos_reg    <= pos_next;
        pos_nx_reg <= pos_nx_next;
        frac_reg   <= frac_next;
        cur_i_reg  <= cur_i_next;
        cur_q_reg  <= cur_q_next;
    end

`ifndef SYNTH
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        arith_req.start |-> !arith_rsp.busy)
        else $error("arithmetic unit started while busy");

    a_done_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        arith_rsp.done |-> (state_reg == ST_MUL_LIM || state_reg == ST_MUL_POS ||
                            state_reg == ST_DIV_FRAC || state_reg == ST_OVR_DIV))
        else $error("arithmetic result arrived with no state waiting for it");

    a_ovr_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (sreq_valid && sreq_ready && sreq.ovr) |=> (state_reg == ST_OVR_DIV))
        else $error("overrun flagged without skipping outputs");
`endif

endmodule
`default_nettype wire

// File: sv/lir_scale.sv
// Interpolates, scales to bytes with rounding and saturation, and holds the output register.
`default_nettype none
module lir_scale (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire lir_pkg::scale_req_t         sreq,
    input  wire logic                        sreq_valid,
    output logic                             sreq_ready,
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic [lir_pkg::OutDataW-1:0]     m_axis_tdata,
    output logic                             m_axis_tlast,
    output logic                             m_axis_tuser
);
    import lir_pkg::*;

    function automatic logic [ByteW-1:0] to_byte(input logic signed [PW-1:0] p);
        logic             neg;
        logic [PW-1:0]    mag;
        logic [PW-1:0]    rsum;
        logic [RW-1:0]    r;
        logic [ByteW-1:0] sat;
        neg  = p[PW-1];
        mag  = neg ? PW'(-p) : PW'(p);
        rsum = mag + (PW'(1) << (RoundShift - 1));
        r    = rsum[PW-1:RoundShift];
        sat  = (r > RW'(ByteMax)) ? ByteW'(ByteMax) : r[ByteW-1:0];
        return neg ? ByteW'(-sat) : sat;
    endfunction

    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic ov_reg, ov_next;

    logic signed [ProdW-1:0]   prod_i_reg, prod_q_reg;
    logic signed [SampleW-1:0] prev_i1_reg, prev_q1_reg;
    logic                      last1_reg, ovr1_reg;
    logic signed [PW-1:0]      p_i2_reg, p_q2_reg;
    logic                      last2_reg, ovr2_reg;
    logic [ByteW-1:0]          out_i_reg, out_q_reg;
    logic                      out_last_reg, out_ovr_reg;

    logic signed [SampleW:0]   diff_i, diff_q;
    logic signed [FracW:0]     frac_s;
    logic signed [ProdW-1:0]   prod_i, prod_q;
    logic signed [YW-1:0]      y_i, y_q;
    logic signed [PW-1:0]      p_i, p_q;
    logic                      take_in;

    // one request in flight at a time
    assign sreq_ready = !v1_reg && !v2_reg && !ov_reg;
    assign take_in    = sreq_valid && sreq_ready;

    assign diff_i = {sreq.cur_i[SampleW-1], sreq.cur_i} - {sreq.prev_i[SampleW-1], sreq.prev_i};
    assign diff_q = {sreq.cur_q[SampleW-1], sreq.cur_q} - {sreq.prev_q[SampleW-1], sreq.prev_q};
    assign frac_s = $signed({1'b0, sreq.frac});
    assign prod_i = frac_s * diff_i;
    assign prod_q = frac_s * diff_q;

    assign y_i = $signed({{(YW-SampleW-16){prev_i1_reg[SampleW-1]}}, prev_i1_reg, 16'b0})
               + $signed({prod_i_reg[ProdW-1], prod_i_reg});
    assign y_q = $signed({{(YW-SampleW-16){prev_q1_reg[SampleW-1]}}, prev_q1_reg, 16'b0})
               + $signed({prod_q_reg[ProdW-1], prod_q_reg});
    // times 127 as shift and subtract
    assign p_i = $signed({y_i, 7'b0}) - $signed({{7{y_i[YW-1]}}, y_i});
    assign p_q = $signed({y_q, 7'b0}) - $signed({{7{y_q[YW-1]}}, y_q});

    always_comb begin
        v1_next = take_in;
        v2_next = v1_reg;
        ov_next = ov_reg;
        if (v2_reg) begin
            ov_next = 1'b1;
        end else if (m_axis_tready) begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            ov_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take_in) begin
            prod_i_reg  <= prod_i;
            prod_q_reg  <= prod_q;
            prev_i1_reg <= sreq.prev_i;
            prev_q1_reg <= sreq.prev_q;
            last1_reg   <= sreq.last;
            ovr1_reg    <= sreq.ovr;
        end
        if (v1_reg) begin
            p_i2_reg  <= p_i;
            p_q2_reg  <= p_q;
            last2_reg <= last1_reg;
            ovr2_reg  <= ovr1_reg;
        end
        if (v2_reg) begin
            out_i_reg    <= to_byte(p_i2_reg);
            out_q_reg    <= to_byte(p_q2_reg);
            out_last_reg <= last2_reg;
            out_ovr_reg  <= ovr2_reg;
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {out_q_reg, out_i_reg};
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_ovr_reg;

`ifndef SYNTH
    a_single_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({v1_reg, v2_reg, ov_reg}))
        else $error("more than one request in the scaling pipeline");

    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        v1_reg |=> (v2_reg && !v1_reg))
        else $error("scaling pipeline failed to advance");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) &&
                                               $stable(m_axis_tlast) && $stable(m_axis_tuser)))
        else $error("output request changed while stalled");
`endif

endmodule
`default_nettype wire

// File: sv/linear_interp_iq_upsampler_unit.sv
// Top level of the linear interpolating IQ upsampler.
//
// Input stream (s_axis_*): one complex sample per request, I in tdata[15:0] and Q in
// tdata[31:16], both Q1.15. Output stream (m_axis_*): one signed IQ byte pair per
// request, I in tdata[7:0] and Q in tdata[15:8]; tlast marks the final byte pair
// caused by an input sample and tuser marks, on that pair, that due outputs beyond
// MAX_RATIO were skipped. A sample may cause no output at all.
// The configuration channel writes in_rate (index 0) and out_rate (index 1); it is
// always ready and is meant to be written while no sample is being worked on.
// The first sample after reset yields one pair.
// A later sample first runs two 25-step products in the shared multiplier, then
// each output pair may need a 16-step fraction divide, and an overrun adds a
// further divide. A two-entry queue takes new samples while the back part is busy
// or the output register waits. Reset restores the default rates and clears history.
// When the receiver stalls, the pending pair holds and the back part waits for it.
`default_nettype none
module linear_interp_iq_upsampler_unit #(
    parameter int MAX_RATIO = lir_pkg::MaxRatio
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [lir_pkg::InDataW-1:0]  s_axis_tdata,   // in_i, in_q
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    output logic [lir_pkg::OutDataW-1:0]      m_axis_tdata,   // out_i, out_q
    output logic                              m_axis_tlast,
    output logic                              m_axis_tuser,   // overrun
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [lir_pkg::CfgIdxW-1:0]  cfg_index,
    input  wire logic [lir_pkg::CfgDataW-1:0] cfg_data
);
    import lir_pkg::*;

    logic [InRateW-1:0]  in_rate_reg, in_rate_next;
    logic [OutRateW-1:0] out_rate_reg, out_rate_next;

    logic       q_full, q_push, q_pop, q_avail;
    item_t      q_in_item, q_out_item;
    arith_req_t arith_req;
    arith_rsp_t arith_rsp;
    scale_req_t sreq;
    logic       sreq_valid, sreq_ready;

    assign cfg_ready = 1'b1;

    always_comb begin
        in_rate_next  = in_rate_reg;
        out_rate_next = out_rate_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CfgIdxInRate:  in_rate_next  = cfg_data[InRateW-1:0];
                CfgIdxOutRate: out_rate_next = cfg_data[OutRateW-1:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_rate_reg  <= InRateReset;
            out_rate_reg <= OutRateReset;
        end else begin
            in_rate_reg  <= in_rate_next;
            out_rate_reg <= out_rate_next;
        end
    end

    lir_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_item        (q_in_item)
    );

    lir_fifo #(
        .WIDTH ($bits(item_t)),
        .DEPTH (QueueDepth)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (q_in_item),
        .full    (q_full),
        .pop     (q_pop),
        .dout    (q_out_item),
        .avail   (q_avail)
    );

    lir_arith u_arith (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (arith_req),
        .rsp     (arith_rsp)
    );

    lir_back #(
        .MAX_RATIO (MAX_RATIO)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item       (q_out_item),
        .item_valid (q_avail),
        .item_pop   (q_pop),
        .in_rate    (in_rate_reg),
        .out_rate   (out_rate_reg),
        .arith_req  (arith_req),
        .arith_rsp  (arith_rsp),
        .sreq       (sreq),
        .sreq_valid (sreq_valid),
        .sreq_ready (sreq_ready)
    );

    lir_scale u_scale (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .sreq          (sreq),
        .sreq_valid    (sreq_valid),
        .sreq_ready    (sreq_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
`default_nettype wire
